>>> design/mbe_pkg.sv
// Shared constants and types for the Mandelbrot escape-time block.
// Used by mbe_core and mandelbrot_escape_time_top; depends on nothing else.

package mbe_pkg;

  localparam int MAX_ITER    = 100000;
  localparam int MAX_DIM     = 4096;

  localparam int COUNT_OUT_W = 17;
  localparam int CNT_W       = ($clog2(MAX_ITER + 1) > COUNT_OUT_W) ?
                               $clog2(MAX_ITER + 1) : COUNT_OUT_W;

  localparam int PIX_W       = 12;
  localparam int DIM_W       = 13;
  localparam int EDGE_W      = 32;
  localparam int STEP_W      = 48;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd5;

  // 2.0 in Q8.56
  localparam logic signed [63:0] TWO_Q56     = 64'sh0200_0000_0000_0000;
  localparam logic signed [63:0] NEG_TWO_Q56 = -TWO_Q56;

  typedef struct packed {
    logic              neg;
    logic [STEP_W-1:0] mag;
  } step_t;

  typedef struct packed {
    logic [PIX_W-1:0]  col;
    logic [PIX_W-1:0]  row;
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] lower;
    step_t             sx;
    step_t             sy;
  } job_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

>>> design/mbe_core.sv
// Escape-time engine: maps a pixel to c and iterates z = z*z + c.
// One shared 32x32 multiplier with a 66-bit accumulator does all products.
// Depends on mbe_pkg.

module mbe_core import mbe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  job_t job,
  output res_t res
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_CRD  = 3'd1;
  localparam logic [2:0] C_SAT  = 3'd2;
  localparam logic [2:0] C_CHK  = 3'd3;
  localparam logic [2:0] C_MUL  = 3'd4;
  localparam logic [2:0] C_UPD  = 3'd5;

  localparam logic [1:0] P_XX = 2'd0;
  localparam logic [1:0] P_YY = 2'd1;
  localparam logic [1:0] P_XY = 2'd2;

  logic [2:0]              state;
  logic                    axis;
  logic [1:0]              k;
  logic [1:0]              pi;
  logic                    done;

  logic [65:0]             acc;
  logic [57:0]             xx, yy, xy;
  logic signed [63:0]      x, y, cx, cy;
  logic [56:0]             xm, ym;
  logic [CNT_W-1:0]        count;
  logic [PIX_W-1:0]        col, row;

  logic [PIX_W-1:0]        idx;
  step_t                   cstep;
  logic [EDGE_W-1:0]       edge_v;
  logic [56:0]             opa, opb;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             prod;
  logic [65:0]             base;
  logic [65:0]             sum;
  logic [57:0]             prod_mag;
  logic [61:0]             e62, a62, v;
  logic                    sat_hi, sat_lo;
  logic [50:0]             sat;
  logic [63:0]             cval;
  logic                    x_far, y_far;
  logic [63:0]             x_neg_v, y_neg_v;
  logic [56:0]             xabs, yabs;
  logic [58:0]             sq_sum;
  logic                    sq_esc;
  logic [63:0]             xy2;
  logic signed [63:0]      nx, ny;

  assign idx    = axis ? row : col;
  assign cstep  = axis ? job.sy : job.sx;
  assign edge_v = axis ? job.lower : job.left;
  assign opa    = (pi == P_YY) ? ym : xm;
  assign opb    = (pi == P_XX) ? xm : ym;

  // operand and accumulator selection for the shared multiplier
  always_comb begin
    if (state == C_CRD) begin
      mul_a = 32'(idx);
      mul_b = k[0] ? cstep.mag[31:0] : 32'(cstep.mag[STEP_W-1:32]);
      base  = k[0] ? {acc[33:0], 32'b0} : 66'd0;
    end else begin
      mul_a = k[1] ? 32'(opa[56:32]) : opa[31:0];
      mul_b = k[0] ? 32'(opb[56:32]) : opb[31:0];
      case (k)
        2'd0:    base = 66'd0;
        2'd2:    base = acc;
        default: base = acc >> 32;
      endcase
    end
  end

  assign prod     = mul_a * mul_b;
  assign sum      = base + 66'(prod);
  // product >> 56: high part from the adder, bits 56..63 from the held word
  assign prod_mag = {sum[49:0], acc[31:24]};

  // coordinate: edge * 2^16 +/- index * |step|, saturated to 51 bits signed
  assign e62    = {{14{edge_v[EDGE_W-1]}}, edge_v, 16'b0};
  assign a62    = {2'b0, acc[59:0]};
  assign v      = cstep.neg ? (e62 - a62) : (e62 + a62);
  assign sat_hi = !v[61] && (|v[60:50]);
  assign sat_lo = v[61] && !(&v[60:50]);
  assign sat    = sat_hi ? {1'b0, {50{1'b1}}} : (sat_lo ? {1'b1, 50'b0} : v[50:0]);
  assign cval   = {sat[50], sat, 12'b0};

  assign x_far   = (x >= TWO_Q56) || (x <= NEG_TWO_Q56);
  assign y_far   = (y >= TWO_Q56) || (y <= NEG_TWO_Q56);
  assign x_neg_v = -x;
  assign y_neg_v = -y;
  assign xabs    = x[63] ? x_neg_v[56:0] : x[56:0];
  assign yabs    = y[63] ? y_neg_v[56:0] : y[56:0];

  assign sq_sum = {1'b0, xx} + {1'b0, yy};
  assign sq_esc = sq_sum[58];

  assign xy2 = {5'b0, xy, 1'b0};
  assign nx  = {6'b0, xx} - {6'b0, yy} + cx;
  assign ny  = (x[63] ^ y[63]) ? (cy - xy2) : (cy + xy2);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      axis  <= 1'b0;
      k     <= 2'd0;
      pi    <= P_XX;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            axis  <= 1'b0;
            k     <= 2'd0;
            state <= C_CRD;
          end
        end
        C_CRD: begin
          if (k[0]) begin
            k     <= 2'd0;
            state <= C_SAT;
          end else begin
            k <= k + 2'd1;
          end
        end
        C_SAT: begin
          if (!axis) begin
            axis  <= 1'b1;
            state <= C_CRD;
          end else begin
            state <= C_CHK;
          end
        end
        C_CHK: begin
          if ((count == CNT_W'(MAX_ITER)) || x_far || y_far) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end else begin
            pi    <= P_XX;
            k     <= 2'd0;
            state <= C_MUL;
          end
        end
        C_MUL: begin
          // squares of the new point are ready: test |z|^2 >= 4
          if ((pi == P_XY) && (k == 2'd0) && sq_esc) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end else begin
            k <= k + 2'd1;
            if (k == 2'd3) begin
              if (pi == P_XY) begin
                state <= C_UPD;
              end else begin
                pi <= pi + 2'd1;
              end
            end
          end
        end
        C_UPD: begin
          state <= C_CHK;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          col   <= job.col;
          row   <= job.row;
          x     <= '0;
          y     <= '0;
          count <= '0;
        end
      end
      C_CRD: begin
        acc <= sum;
      end
      C_SAT: begin
        if (axis) begin
          cy <= cval;
        end else begin
          cx <= cval;
        end
      end
      C_CHK: begin
        xm <= xabs;
        ym <= yabs;
      end
      C_MUL: begin
        acc <= sum;
        if (k == 2'd3) begin
          case (pi)
            P_XX:    xx <= prod_mag;
            P_YY:    yy <= prod_mag;
            default: xy <= prod_mag;
          endcase
        end
      end
      C_UPD: begin
        x     <= nx;
        y     <= ny;
        count <= count + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign res.done  = done;
  assign res.count = count;

endmodule

>>> design/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time block: configuration registers,
// step divider, handshakes and result register. Depends on mbe_pkg, mbe_core.
//
//   channel  | direction | handshake             | word
//   ---------+-----------+-----------------------+------------------------------
//   pixel    | in        | pixel_valid/_stall    | pixel_col, pixel_row
//   result   | out       | result_valid/_stall   | iteration_count
//   cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A pixel takes a set-up phase plus up to MAX_ITER iterations; the single shared
// 32x32 multiplier sets the pace, as each iteration needs three 57-bit products
// of four partial products each. After reset and after any write to one of the
// six configuration registers the steps are rederived by a one-bit-per-cycle
// divider, during which pixel_stall is high.
// A finished count moves to the result register, so the next pixel is taken
// while the previous word still waits under result_stall.

module mandelbrot_escape_time_top import mbe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic [PIX_W-1:0]       pixel_col,
  input  logic [PIX_W-1:0]       pixel_row,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [COUNT_OUT_W-1:0] iteration_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [EDGE_W-1:0]      cfg_data
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_DIV  = 2'd1;
  localparam logic [1:0] T_RUN  = 2'd2;
  localparam logic [1:0] T_OUT  = 2'd3;

  logic [1:0]              tstate;
  logic                    stale;

  logic [EDGE_W-1:0]       plane_left, plane_right, plane_lower, plane_upper;
  logic [DIM_W-1:0]        image_columns, image_rows;

  logic [STEP_W-1:0]       quo;
  logic [DIM_W-1:0]        rem;
  logic [DIM_W-1:0]        ddiv;
  logic [5:0]              dcnt;
  logic                    dax;
  logic                    dneg;
  step_t                   sx, sy;

  logic [COUNT_OUT_W-1:0]  result_count;

  logic                    cfg_wr;
  logic                    pix_acc;
  logic                    out_load;
  logic [EDGE_W:0]         dx, dy, dx_neg, dy_neg;
  logic [STEP_W-1:0]       dvd_x, dvd_y;
  logic [DIM_W-1:0]        div_x, div_y;
  logic [DIM_W:0]          trial, tdiff;
  logic                    ge;
  logic [DIM_W-1:0]        rem_next;
  logic [STEP_W-1:0]       quo_next;

  job_t                    job;
  res_t                    core_res;

  function automatic logic [DIM_W-1:0] div_of(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if ({4'b0, d} > 17'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign pixel_stall = !((tstate == T_IDLE) && !stale);
  assign pix_acc     = pixel_valid && !pixel_stall;
  assign out_load    = (tstate == T_OUT) && (!result_valid || !result_stall);

  // spans and dividends, |span| * 2^16
  assign dx     = {plane_right[EDGE_W-1], plane_right} - {plane_left[EDGE_W-1], plane_left};
  assign dy     = {plane_upper[EDGE_W-1], plane_upper} - {plane_lower[EDGE_W-1], plane_lower};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign dvd_x  = {(dx[EDGE_W] ? dx_neg[EDGE_W-1:0] : dx[EDGE_W-1:0]), 16'b0};
  assign dvd_y  = {(dy[EDGE_W] ? dy_neg[EDGE_W-1:0] : dy[EDGE_W-1:0]), 16'b0};
  assign div_x  = div_of(image_columns);
  assign div_y  = div_of(image_rows);

  // restoring division, one quotient bit a cycle
  assign trial    = {rem, quo[STEP_W-1]};
  assign ge       = trial >= {1'b0, ddiv};
  assign tdiff    = trial - {1'b0, ddiv};
  assign rem_next = ge ? tdiff[DIM_W-1:0] : trial[DIM_W-1:0];
  assign quo_next = {quo[STEP_W-2:0], ge};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_left    <= 32'hE000_0000;
      plane_right   <= 32'h1000_0000;
      plane_lower   <= 32'hF000_0000;
      plane_upper   <= 32'h1000_0000;
      image_columns <= DIM_W'(1024);
      image_rows    <= DIM_W'(1024);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_LEFT:  plane_left    <= cfg_data;
        REG_RIGHT: plane_right   <= cfg_data;
        REG_LOWER: plane_lower   <= cfg_data;
        REG_UPPER: plane_upper   <= cfg_data;
        REG_COLS:  image_columns <= cfg_data[DIM_W-1:0];
        REG_ROWS:  image_rows    <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate       <= T_IDLE;
      stale        <= 1'b1;
      dax          <= 1'b0;
      dcnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      case (tstate)
        T_IDLE: begin
          if (stale) begin
            dax    <= 1'b0;
            dcnt   <= '0;
            tstate <= T_DIV;
          end else if (pix_acc) begin
            tstate <= T_RUN;
          end
        end
        T_DIV: begin
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(STEP_W - 1)) begin
            dcnt <= '0;
            if (!dax) begin
              dax <= 1'b1;
            end else begin
              tstate <= T_IDLE;
            end
          end
        end
        T_RUN: begin
          if (core_res.done) begin
            tstate <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_load) begin
            tstate <= T_IDLE;
          end
        end
        default: begin
          tstate <= T_IDLE;
        end
      endcase

      // a write wins over the clear, so a late write forces another pass
      if (cfg_wr && (cfg_index <= REG_ROWS)) begin
        stale <= 1'b1;
      end else if ((tstate == T_IDLE) && stale) begin
        stale <= 1'b0;
      end

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // divider datapath and result word
  always_ff @(posedge clk) begin
    if ((tstate == T_IDLE) && stale) begin
      quo  <= dvd_x;
      rem  <= '0;
      ddiv <= div_x;
      dneg <= dx[EDGE_W];
    end else if (tstate == T_DIV) begin
      quo <= quo_next;
      rem <= rem_next;
      if (dcnt == 6'(STEP_W - 1)) begin
        if (!dax) begin
          sx.mag <= quo_next;
          sx.neg <= dneg;
          quo    <= dvd_y;
          rem    <= '0;
          ddiv   <= div_y;
          dneg   <= dy[EDGE_W];
        end else begin
          sy.mag <= quo_next;
          sy.neg <= dneg;
        end
      end
    end
    if (out_load) begin
      result_count <= core_res.count[COUNT_OUT_W-1:0];
    end
  end

  assign job.col   = pixel_col;
  assign job.row   = pixel_row;
  assign job.left  = plane_left;
  assign job.lower = plane_lower;
  assign job.sx    = sx;
  assign job.sy    = sy;

  mbe_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (pix_acc),
    .job   (job),
    .res   (core_res)
  );

  assign iteration_count = result_count;

`ifndef SYNTHESIS
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    core_res.done |-> (tstate == T_RUN))
    else $error("engine finished while no pixel was in flight");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (tstate == T_DIV) |-> (rem < ddiv))
    else $error("divider remainder not below divisor");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(tstate) == T_OUT))
    else $error("result word raised outside the hand-over state");
`endif

endmodule

>>> tb/tb.sv
// Testbench for mandelbrot_escape_time_top: predicts each pixel's iteration count from
// the configured plane in fixed point and checks the result words in order.
// Depends on mbe_pkg and the design files only.

module tb;
  import mbe_pkg::*;

  localparam longint ESC_TWO     = 64'sh0200_0000_0000_0000;  // 2.0 in Q8.56
  localparam longint ESC_FOUR    = 64'sh0400_0000_0000_0000;  // 4.0 in Q8.56
  localparam longint COORD_LIMIT = 64'sh0004_0000_0000_0000;  // 64.0 in Q.44

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned ITER_CAP        = 300;
  localparam int unsigned QUICK_CAP       = 8;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          TAIL_CYCLES     = 500;
  localparam int          WATCHDOG_CYCLES = 4 * 14 * MAX_ITER + 20000;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   pixel_valid  = 1'b0;
  logic                   pixel_stall;
  logic [PIX_W-1:0]       pixel_col    = '0;
  logic [PIX_W-1:0]       pixel_row    = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [COUNT_OUT_W-1:0] iteration_count;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index    = '0;
  logic [EDGE_W-1:0]      cfg_data     = '0;

  // predictor copy of the registers and the derived steps (Q.44)
  logic [EDGE_W-1:0] reg_left, reg_right, reg_lower, reg_upper;
  logic [DIM_W-1:0]  reg_cols, reg_rows;
  longint            step_x, step_y;

  logic [COUNT_OUT_W-1:0] expected_counts[$];
  logic [COUNT_OUT_W-1:0] want_count;
  int                     fail_count     = 0;
  int                     quiet_cycles   = 0;
  int                     send_gap_pct   = 0;
  int                     recv_stall_pct = 0;
  int                     stall_hold_len = 0;

  mandelbrot_escape_time_top dut (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .pixel_col       (pixel_col),
    .pixel_row       (pixel_row),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .iteration_count (iteration_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint grid_divisor(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return longint'(v);
  endfunction

  function automatic void update_steps();
    longint dx, dy;
    dx = longint'($signed(reg_right)) - longint'($signed(reg_left));
    dy = longint'($signed(reg_upper)) - longint'($signed(reg_lower));
    step_x = (dx * 65536) / grid_divisor(reg_cols);
    step_y = (dy * 65536) / grid_divisor(reg_rows);
  endfunction

  // Q.44 edge plus index times step, clamped to +-64, widened to Q8.56
  function automatic longint plane_coord(logic [EDGE_W-1:0] origin, logic [PIX_W-1:0] idx,
                                         longint step);
    longint v;
    v = longint'($signed(origin)) * 65536 + longint'(idx) * step;
    if (v > COORD_LIMIT - 1) v = COORD_LIMIT - 1;
    if (v < -COORD_LIMIT) v = -COORD_LIMIT;
    return v * 4096;
  endfunction

  // full-width product of magnitudes, truncated toward zero, sign applied after
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0]  mag_a, mag_b;
    logic [127:0] prod;
    longint       mag;
    mag_a = (a < 0) ? 64'(-a) : 64'(a);
    mag_b = (b < 0) ? 64'(-b) : 64'(b);
    prod  = {64'd0, mag_a} * {64'd0, mag_b};
    mag   = longint'({1'b0, prod[118:56]});
    return ((a < 0) != (b < 0)) ? -mag : mag;
  endfunction

  function automatic int unsigned escape_count(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                                               int unsigned limit);
    longint      cx, cy, x, y, xx, yy, xy, nx;
    int unsigned n;
    bit          gone;
    cx   = plane_coord(reg_left, col, step_x);
    cy   = plane_coord(reg_lower, row, step_y);
    x    = 0;
    y    = 0;
    n    = 0;
    gone = 1'b0;
    while (n < limit && !gone) begin
      xx = fx_mul(x, x);
      yy = fx_mul(y, y);
      xy = fx_mul(x, y);
      nx = xx - yy + cx;
      y  = 2 * xy + cy;
      x  = nx;
      n++;
      // a component at 2 or beyond has escaped without squaring
      if (x >= ESC_TWO || x <= -ESC_TWO || y >= ESC_TWO || y <= -ESC_TWO) gone = 1'b1;
      else if (fx_mul(x, x) + fx_mul(y, y) >= ESC_FOUR) gone = 1'b1;
    end
    return n;
  endfunction

  // draw a pixel that escapes within cap iterations; mostly inside the image
  function automatic bit pick_pixel(output logic [PIX_W-1:0] col, output logic [PIX_W-1:0] row,
                                    input int unsigned cap);
    longint span_c, span_r;
    span_c = grid_divisor(reg_cols);
    span_r = grid_divisor(reg_rows);
    for (int t = 0; t < 64; t++) begin
      if ($urandom_range(99) < 70) begin
        col = PIX_W'($urandom_range(int'(span_c) - 1, 0));
        row = PIX_W'($urandom_range(int'(span_r) - 1, 0));
      end else begin
        col = PIX_W'($urandom);
        row = PIX_W'($urandom);
      end
      if (escape_count(col, row, cap) < cap) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EDGE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEFT:  reg_left  = data;
      REG_RIGHT: reg_right = data;
      REG_LOWER: reg_lower = data;
      REG_UPPER: reg_upper = data;
      REG_COLS:  reg_cols  = data[DIM_W-1:0];
      REG_ROWS:  reg_rows  = data[DIM_W-1:0];
      default: ;
    endcase
    update_steps();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_plane(logic [EDGE_W-1:0] left_w, logic [EDGE_W-1:0] right_w,
                             logic [EDGE_W-1:0] lower_w, logic [EDGE_W-1:0] upper_w,
                             logic [EDGE_W-1:0] cols_w, logic [EDGE_W-1:0] rows_w);
    write_reg(REG_LEFT, left_w);
    write_reg(REG_RIGHT, right_w);
    write_reg(REG_LOWER, lower_w);
    write_reg(REG_UPPER, upper_w);
    write_reg(REG_COLS, cols_w);
    write_reg(REG_ROWS, rows_w);
  endtask

  // valid stays high after acceptance; the next call or wait_idle decides
  task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    while ($urandom_range(99) < send_gap_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_col   <= col;
    pixel_row   <= row;
    do @(posedge clk); while (pixel_stall);
    expected_counts.push_back(COUNT_OUT_W'(escape_count(col, row, MAX_ITER)));
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (expected_counts.size() != 0);
  endtask

  task automatic test_reset_config();
    send_pixel(12'd0, 12'd0);        // real part exactly -2
    send_pixel(12'd4095, 12'd4095);  // well beyond the image
    send_pixel(12'd1023, 12'd0);
    send_pixel(12'd0, 12'd1023);
    send_pixel(12'd1195, 12'd1280);  // escapes on |z|^2 with both parts below 2
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    wait_idle();
  endtask

  task automatic test_far_points();
    // widest plane, divisors of zero: steps of about 16, clamp at the top
    apply_plane(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h0000_0000, 32'h0000_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    wait_idle();
    // reversed plane; columns over the maximum, rows masked down to zero
    apply_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'hffff_ffff, 32'h0000_2000);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd1);
    wait_idle();
    // unused indexes must leave the plane alone
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    send_pixel(12'd4095, 12'd0);
    wait_idle();
  endtask

  task automatic test_iteration_limit();
    apply_plane(32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 32'h1000_0000,
                32'd4096, 32'd4096);
    send_pixel(12'd1065, 12'd0);     // just past the cusp: slow escape
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);        // origin never escapes
    wait_idle();
  endtask

  task automatic test_random_phase(int gap_pct, int stall_pct);
    logic [EDGE_W-1:0] left_w, right_w, lower_w, upper_w, cols_w, rows_w;
    logic [PIX_W-1:0]  col, row;
    bit                found;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 3; k++) begin
      if (k == 1) begin
        left_w  = $urandom;
        right_w = $urandom;
        lower_w = $urandom;
        upper_w = $urandom;
        cols_w  = $urandom;
        rows_w  = $urandom;
      end else begin
        // window around the set, Q4.28
        left_w  = -int'($urandom_range(5 << 27, 1 << 27));
        right_w = int'($urandom_range(3 << 27, 0));
        lower_w = -int'($urandom_range(3 << 27, 1 << 25));
        upper_w = int'($urandom_range(3 << 27, 1 << 25));
        cols_w  = $urandom_range(1024, 8);
        rows_w  = $urandom_range(1024, 8);
      end
      apply_plane(left_w, right_w, lower_w, upper_w, cols_w, rows_w);
      for (int n = 0; n < 8; n++) begin
        found = pick_pixel(col, row, ITER_CAP);
        if (found) send_pixel(col, row);
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    logic [PIX_W-1:0] col, row;
    bit               found;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    stall_hold_len = HOLD_CYCLES;
    for (int n = 0; n < 8; n++) begin
      found = pick_pixel(col, row, QUICK_CAP);
      if (found) send_pixel(col, row);
    end
    wait_idle();
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_counts.size() == 0) begin
        $error("iteration_count: expected none, got %0d", iteration_count);
        fail_count++;
      end else begin
        want_count = expected_counts.pop_front();
        if (iteration_count !== want_count) begin
          $error("iteration_count: expected %0d, got %0d", want_count, iteration_count);
          fail_count++;
        end
      end
    end
    if (stall_hold_len > 0) begin
      result_stall <= 1'b1;
      stall_hold_len--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    reg_left  = 32'he000_0000;
    reg_right = 32'h1000_0000;
    reg_lower = 32'hf000_0000;
    reg_upper = 32'h1000_0000;
    reg_cols  = 13'd1024;
    reg_rows  = 13'd1024;
    update_steps();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct   = 25;
    recv_stall_pct = 76;
    test_reset_config();
    test_far_points();
    test_iteration_limit();
    test_random_phase(25, 76);
    test_random_phase(76, 25);
    test_random_phase(0, 0);
    test_backpressure();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> mandelbrot_escape_time_top.f
design/mbe_pkg.sv
design/mbe_core.sv
design/mandelbrot_escape_time_top.sv
tb/tb.sv
